FILE: rtl/core/dual_ring_fifo_word_packer_core_defines.svh
// Assertion helpers shared by the packer core.
`ifndef DUAL_RING_FIFO_WORD_PACKER_CORE_DEFINES_SVH
`define DUAL_RING_FIFO_WORD_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define DRFWP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define DRFWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/drfwp_pkg.sv
`default_nettype none
package drfwp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 2 * BYTE_W;
  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned TX_DEPTH = 256;
  localparam int unsigned RX_AW    = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW    = $clog2(TX_DEPTH);

  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_RX_PUSH = 2'd0,
    OP_RX_POP  = 2'd1,
    OP_TX_PUSH = 2'd2,
    OP_TX_POP  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RX_RD,
    ST_TX_RD0,
    ST_TX_RD1,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic [RX_AW-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [RX_AW-1:0]  rd_addr;
  } rx_mem_req_t;

  typedef struct packed {
    logic              wr_en;
    logic [TX_AW-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [TX_AW-1:0]  rd_addr;
  } tx_mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic [1:0]        count;
  } rsp_t;

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] ptr);
    return (ptr == RX_LAST) ? '0 : ptr + RX_AW'(1);
  endfunction

  function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] ptr);
    return (ptr == TX_LAST) ? '0 : ptr + TX_AW'(1);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/drfwp_ram.sv
`default_nettype none
module drfwp_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register read data; hold it between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/drfwp_seq.sv
`default_nettype none
module drfwp_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [drfwp_pkg::BYTE_W-1:0] data_byte_i,
  output drfwp_pkg::rx_mem_req_t           rx_req_o,
  input  wire logic [drfwp_pkg::BYTE_W-1:0] rx_rdata_i,
  output drfwp_pkg::tx_mem_req_t           tx_req_o,
  input  wire logic [drfwp_pkg::BYTE_W-1:0] tx_rdata_i,
  output drfwp_pkg::rsp_t                  rsp_o,
  input  wire logic                        rsp_take_i
);
  import drfwp_pkg::*;

  state_e            state_q, state_d;
  opcode_e           op;
  logic              in_acc;
  logic              rx_empty, tx_empty, tx_more;
  logic [RX_AW-1:0]  rx_wr_q, rx_rd_q;
  logic [TX_AW-1:0]  tx_wr_q, tx_rd_q;
  logic [WORD_W-1:0] word_q;
  logic [1:0]        count_q;

  assign op       = opcode_e'(opcode_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign rx_empty = (rx_rd_q == rx_wr_q);
  assign tx_empty = (tx_rd_q == tx_wr_q);
  // After the first transmit read the pointer has advanced; compare again
  assign tx_more  = (tx_rd_q != tx_wr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_RX_POP: state_d = rx_empty ? ST_RESP : ST_RX_RD;
            OP_TX_POP: state_d = tx_empty ? ST_RESP : ST_TX_RD0;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_RX_RD:  state_d = ST_RESP;
      ST_TX_RD0: state_d = tx_more ? ST_TX_RD1 : ST_RESP;
      ST_TX_RD1: state_d = ST_RESP;
      ST_RESP:   state_d = rsp_take_i ? ST_IDLE : ST_RESP;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory requests
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    rx_req_o.wr_en   = in_acc && (op == OP_RX_PUSH);
    rx_req_o.wr_addr = rx_wr_q;
    rx_req_o.wr_data = data_byte_i;
    rx_req_o.rd_en   = in_acc && (op == OP_RX_POP) && !rx_empty;
    rx_req_o.rd_addr = rx_rd_q;
    tx_req_o.wr_en   = in_acc && (op == OP_TX_PUSH);
    tx_req_o.wr_addr = tx_wr_q;
    tx_req_o.wr_data = data_byte_i;
    tx_req_o.rd_en   = (in_acc && (op == OP_TX_POP) && !tx_empty)
                    || ((state_q == ST_TX_RD0) && tx_more);
    tx_req_o.rd_addr = tx_rd_q;
    rsp_o.valid      = (state_q == ST_RESP);
    rsp_o.word       = word_q;
    rsp_o.count      = count_q;
  end

  // Advance state and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rx_wr_q <= '0;
      rx_rd_q <= '0;
      tx_wr_q <= '0;
      tx_rd_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_RX_PUSH: rx_wr_q <= rx_next(rx_wr_q);
              OP_RX_POP:  if (!rx_empty) rx_rd_q <= rx_next(rx_rd_q);
              OP_TX_PUSH: tx_wr_q <= tx_next(tx_wr_q);
              OP_TX_POP:  if (!tx_empty) tx_rd_q <= tx_next(tx_rd_q);
              default:    ;
            endcase
          end
        end
        ST_TX_RD0: if (tx_more) tx_rd_q <= tx_next(tx_rd_q);
        default:   ;
      endcase
    end
  end

  // Assemble the result word from read data
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          word_q  <= '0;
          count_q <= 2'd0;
        end
      end
      ST_RX_RD: begin
        word_q  <= {{(WORD_W - BYTE_W){1'b0}}, rx_rdata_i};
        count_q <= 2'd1;
      end
      ST_TX_RD0: begin
        word_q[BYTE_W-1:0] <= tx_rdata_i;
        count_q            <= 2'd1;
      end
      ST_TX_RD1: begin
        word_q[WORD_W-1:BYTE_W] <= tx_rdata_i;
        count_q                 <= 2'd2;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/dual_ring_fifo_word_packer_core.sv
// Dual byte ring buffer with word packing on the transmit side.
// Input channel (in_valid_i/in_ready_o) carries one operation per beat:
// receive push, receive pop, transmit push or transmit pop word. Output
// channel (out_valid_o/out_ready_i) returns exactly one beat per operation,
// in order: data_word_o and byte_count_o (0 for a push or an empty pop).
// One operation is in work at a time. Pushes and empty pops read nothing; a
// receive pop takes one read of the receive memory and a transmit pop one
// or two through the single read port of the transmit memory, one per
// cycle, the second only when a second byte is stored; every read result
// is registered by the memory. A new operation is taken only once the
// previous result has left the sequencer.
// The result register parts the two sides: a new operation is taken while
// a finished result still waits; when the receiver stalls, the next result
// waits inside the sequencer and no further beat is accepted.
// Reset clears the four ring pointers (both rings empty) and the control
// state; memory contents are left as they are and are never read unwritten.
`default_nettype none
`include "dual_ring_fifo_word_packer_core_defines.svh"
module dual_ring_fifo_word_packer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [drfwp_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                         last_in_burst_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [drfwp_pkg::WORD_W-1:0]      data_word_o,
  output logic [1:0]                        byte_count_o
);
  import drfwp_pkg::*;

  rx_mem_req_t       rx_req;
  tx_mem_req_t       tx_req;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;
  rsp_t              rsp;
  logic              rsp_take;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [1:0]        out_count_q;
  logic              beat_empty, beat_single;
  logic [BYTE_W-1:0] high_byte;

  drfwp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .rx_req_o    (rx_req),
    .rx_rdata_i  (rx_rdata),
    .tx_req_o    (tx_req),
    .tx_rdata_i  (tx_rdata),
    .rsp_o       (rsp),
    .rsp_take_i  (rsp_take)
  );

  drfwp_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rx_req.wr_en),
    .wr_addr_i (rx_req.wr_addr),
    .wr_data_i (rx_req.wr_data),
    .rd_en_i   (rx_req.rd_en),
    .rd_addr_i (rx_req.rd_addr),
    .rd_data_o (rx_rdata)
  );

  drfwp_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tx_req.wr_en),
    .wr_addr_i (tx_req.wr_addr),
    .wr_data_i (tx_req.wr_data),
    .rd_en_i   (tx_req.rd_en),
    .rd_addr_i (tx_req.rd_addr),
    .rd_data_o (tx_rdata)
  );

  // Load the result register when it is empty or being drained
  assign rsp_take = rsp.valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_take) begin
      out_word_q  <= rsp.word;
      out_count_q <= rsp.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_word_o  = out_word_q;
  assign byte_count_o = out_count_q;

  // Classify the result beat for the checks below
  assign beat_empty  = out_valid_o && (byte_count_o == 2'd0);
  assign beat_single = out_valid_o && (byte_count_o == 2'd1);
  assign high_byte   = data_word_o[WORD_W-1:BYTE_W];

  `DRFWP_ASSERT_NEXT(a_one_in_work, in_valid_i && in_ready_o, !in_ready_o, "beat taken while busy")
  `DRFWP_ASSERT_NOW(a_count_range, out_valid_o, byte_count_o != 2'd3, "byte count out of range")
  `DRFWP_ASSERT_NOW(a_zero_count_word, beat_empty, data_word_o == '0, "word set on empty beat")
  `DRFWP_ASSERT_NOW(a_one_byte_high, beat_single, high_byte == '0, "high byte on single byte")

endmodule
`default_nettype wire
